### rtl/core/pti_pkg.sv
// shared types, codes and constants of the polar table interpolator
`default_nettype none
package pti_pkg;

   localparam int MaxRows  = 256;
   localparam int AddrW    = $clog2(MaxRows);
   localparam int CntW     = $clog2(MaxRows + 1);
   localparam int ReW      = 24;
   localparam int CoefW    = 16;
   localparam int FracW    = 16;
   localparam int DivSteps = FracW;
   localparam logic [17:0] ClipQ16 = 18'd54067;
   localparam logic [16:0] FracOne = 17'd65536;

   localparam logic [1:0] CmdClear  = 2'd0;
   localparam logic [1:0] CmdAppend = 2'd1;
   localparam logic [1:0] CmdQuery  = 2'd2;
   localparam logic [1:0] CmdUnused = 2'd3;

   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatEmpty = 2'd1;
   localparam logic [1:0] StatFull  = 2'd2;
   localparam logic [1:0] StatEnded = 2'd3;

   localparam logic [1:0] RangeIn    = 2'd0;
   localparam logic [1:0] RangeAbove = 2'd1;
   localparam logic [1:0] RangeBelow = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [ReW-1:0]          reynolds;
      logic signed [CoefW-1:0] lift_coef;
      logic [CoefW-1:0]        drag_coef;
      logic signed [CoefW-1:0] moment_coef;
   } req_type;

   typedef struct packed {
      logic [CoefW-1:0]        drag_out;
      logic signed [CoefW-1:0] moment_out;
      logic signed [CoefW-1:0] lift_out;
      logic                    stall_flag;
      logic                    low_lift_flag;
      logic [1:0]              reynolds_range;
      logic [1:0]              status;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/core/pti_div.sv
// restoring divider giving a 16-bit fraction num * 2^16 / den for 0 < num < den
`default_nettype none
module pti_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pti_pkg::ReW-1:0]   num,
   input  wire logic [pti_pkg::ReW-1:0]   den,
   output logic                           done,
   output logic [pti_pkg::FracW-1:0]      quo
);

   localparam int StepW = $clog2(pti_pkg::DivSteps + 1);

   logic [StepW-1:0]          step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [pti_pkg::ReW:0]     rem_ff, rem_in;
   logic [pti_pkg::ReW-1:0]   den_ff, den_in;
   logic [pti_pkg::FracW-1:0] quo_ff, quo_in;
   logic [pti_pkg::ReW:0]     rem2;
   logic                      ge;

   always_comb begin
      rem2    = {rem_ff[pti_pkg::ReW-1:0], 1'b0};
      ge      = rem2 >= {1'b0, den_ff};
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? rem2 - {1'b0, den_ff} : rem2;
         quo_in  = {quo_ff[pti_pkg::FracW-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == StepW'(pti_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

### rtl/core/polar_table_interpolator.sv
// top level of the polar table interpolator: row table, query sequencer, shared multiplier
`default_nettype none
// Keeps up to 256 polar rows (Reynolds number, lift, drag, moment) loaded by append
// items and answers query items with drag and moment interpolated in lift within the
// neighboring Reynolds groups and then in Reynolds number. Every item gives exactly one
// result item. A query walks the table through one registered memory read port, one row
// a cycle: it fetches the table ends, scans rows to find the Reynolds group and walks
// the rows of each group, then runs each interpolation through the bit-serial divider
// and the one shared multiplier, and each stall clip through that multiplier. The block
// takes no new item while a query runs; a finished result waits in the output register
// while the next item is taken.
module polar_table_interpolator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pti_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pti_pkg::rsp_type      rsp_item
);

   // sequencer states
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_LO    = 14'b00000000000010,
      S_HI    = 14'b00000000000100,
      S_SCAN  = 14'b00000000001000,
      S_GRP   = 14'b00000000010000,
      S_CLIP  = 14'b00000000100000,
      S_CLIPW = 14'b00000001000000,
      S_FRAC  = 14'b00000010000000,
      S_DIVW  = 14'b00000100000000,
      S_MULD  = 14'b00001000000000,
      S_MULM  = 14'b00010000000000,
      S_MULF  = 14'b00100000000000,
      S_NEXT  = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   // what a finished group search or interpolation feeds next
   typedef enum logic [3:0] {
      PH_SINGLE = 4'b0001,
      PH_LOWER  = 4'b0010,
      PH_UPPER  = 4'b0100,
      PH_REY    = 4'b1000
   } phase_type;

   localparam int AW = pti_pkg::AddrW;
   localparam int CW = pti_pkg::CntW;
   localparam int RW = pti_pkg::ReW;
   localparam int KW = pti_pkg::CoefW;

   // row table
   logic [RW+3*KW-1:0] mem [pti_pkg::MaxRows];
   logic [RW+3*KW-1:0] mem_q_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;

   logic [RW-1:0]       q_re;
   logic signed [KW-1:0] q_lift;
   logic [KW-1:0]       q_drag;
   logic signed [KW-1:0] q_mom;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [CW-1:0]  count_ff, count_in;
   logic           ended_ff, ended_in;
   logic [RW-1:0]  re_ff, re_in;
   logic [RW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic [RW-1:0]  prev_re_ff, prev_re_in;
   logic [RW-1:0]  rey_a_ff, rey_a_in;
   logic [RW-1:0]  rey_b_ff, rey_b_in;
   logic [CW-1:0]  top_ff, top_in;
   logic [CW-1:0]  gi_ff, gi_in;
   logic [RW-1:0]  gref_ff, gref_in;
   logic           up_ff, up_in;

   logic signed [KW-1:0] cl_ff, cl_in;
   logic signed [KW-1:0] p_lift_ff, p_lift_in;
   logic signed [KW:0]   p_drag_ff, p_drag_in;
   logic signed [KW:0]   p_mom_ff, p_mom_in;

   logic signed [KW:0] res_d_ff, res_d_in;
   logic signed [KW:0] res_m_ff, res_m_in;
   logic signed [KW:0] cd1_ff, cd1_in;
   logic signed [KW:0] cm1_ff, cm1_in;
   logic signed [KW:0] ja_d_ff, ja_d_in;
   logic signed [KW:0] jb_d_ff, jb_d_in;
   logic signed [KW:0] ja_m_ff, ja_m_in;
   logic signed [KW:0] jb_m_ff, jb_m_in;
   logic signed [RW:0] jnum_ff, jnum_in;
   logic signed [RW:0] jden_ff, jden_in;
   logic [16:0]        f_ff, f_in;

   // shared multiplier, registered product
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod_ff, prod_in;

   logic         stall_ff, stall_in;
   logic         low_ff, low_in;
   logic [1:0]   range_ff, range_in;
   logic [1:0]   status_ff, status_in;

   pti_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic                       div_start;
   logic                       div_done;
   logic [pti_pkg::FracW-1:0]  div_quo;

   logic first, same, cont;
   logic signed [KW:0] q_drag_s, q_mom_s;

   pti_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (jnum_ff[RW-1:0]),
      .den   (jden_ff[RW-1:0]),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign q_re     = mem_q_ff[RW+3*KW-1:3*KW];
   assign q_lift   = signed'(mem_q_ff[3*KW-1:2*KW]);
   assign q_drag   = mem_q_ff[2*KW-1:KW];
   assign q_mom    = signed'(mem_q_ff[KW-1:0]);
   assign q_drag_s = signed'({1'b0, q_drag});
   assign q_mom_s  = signed'((KW+1)'(q_mom));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      ended_in     = ended_ff;
      re_in        = re_ff;
      lo_in        = lo_ff;
      scan_in      = scan_ff;
      prev_re_in   = prev_re_ff;
      rey_a_in     = rey_a_ff;
      rey_b_in     = rey_b_ff;
      top_in       = top_ff;
      gi_in        = gi_ff;
      gref_in      = gref_ff;
      up_in        = up_ff;
      cl_in        = cl_ff;
      p_lift_in    = p_lift_ff;
      p_drag_in    = p_drag_ff;
      p_mom_in     = p_mom_ff;
      res_d_in     = res_d_ff;
      res_m_in     = res_m_ff;
      cd1_in       = cd1_ff;
      cm1_in       = cm1_ff;
      ja_d_in      = ja_d_ff;
      jb_d_in      = jb_d_ff;
      ja_m_in      = ja_m_ff;
      jb_m_in      = jb_m_ff;
      jnum_in      = jnum_ff;
      jden_in      = jden_ff;
      f_in         = f_ff;
      stall_in     = stall_ff;
      low_in       = low_ff;
      range_in     = range_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = '0;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      prod_in      = prod_ff;
      first        = (gi_ff == top_ff);
      same         = first || (q_re == gref_ff);
      cont         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // non-query items report zeros but for status
               res_d_in  = '0;
               res_m_in  = '0;
               cl_in     = '0;
               stall_in  = 1'b0;
               low_in    = 1'b0;
               range_in  = pti_pkg::RangeIn;
               status_in = pti_pkg::StatOk;
               state_in  = S_OUT;
               case (req_item.cmd)
                  pti_pkg::CmdClear: begin
                     count_in = '0;
                     ended_in = 1'b0;
                  end
                  pti_pkg::CmdAppend: begin
                     if (ended_ff) begin
                        status_in = pti_pkg::StatEnded;
                     end else if (req_item.reynolds == '0) begin
                        ended_in = 1'b1;
                     end else if (count_ff >= CW'(pti_pkg::MaxRows)) begin
                        status_in = pti_pkg::StatFull;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pti_pkg::CmdQuery: begin
                     re_in = req_item.reynolds;
                     cl_in = req_item.lift_coef;
                     if (count_ff == '0) begin
                        status_in = pti_pkg::StatEmpty;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_LO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LO: begin
            lo_in    = q_re;
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = S_HI;
         end
         S_HI: begin
            if (re_ff > lo_ff && re_ff < q_re) begin
               phase_in = PH_LOWER;
               scan_in  = '0;
               rd_addr  = '0;
               state_in = S_SCAN;
            end else if (re_ff >= q_re) begin
               range_in = pti_pkg::RangeAbove;
               phase_in = PH_SINGLE;
               up_in    = 1'b0;
               top_in   = count_ff - 1'b1;
               gi_in    = count_ff - 1'b1;
               rd_addr  = AW'(count_ff - 1'b1);
               state_in = S_GRP;
            end else begin
               range_in = pti_pkg::RangeBelow;
               phase_in = PH_SINGLE;
               up_in    = 1'b1;
               top_in   = '0;
               gi_in    = '0;
               rd_addr  = '0;
               state_in = S_GRP;
            end
         end
         S_SCAN: begin
            // first row at or above the query Reynolds number; row zero is always below
            if (scan_ff < count_ff - 1'b1 && q_re < re_ff) begin
               prev_re_in = q_re;
               scan_in    = scan_ff + 1'b1;
               rd_addr    = AW'(scan_ff + 1'b1);
            end else begin
               rey_a_in = prev_re_ff;
               rey_b_in = q_re;
               top_in   = scan_ff - 1'b1;
               gi_in    = scan_ff - 1'b1;
               up_in    = 1'b0;
               rd_addr  = AW'(scan_ff - 1'b1);
               state_in = S_GRP;
            end
         end
         S_GRP: begin
            if (first) begin
               gref_in = q_re;
            end
            if (!up_ff) begin
               // walk down from the group top while lift is above the query
               cont = same && (q_lift > cl_ff);
               if (cont) begin
                  p_lift_in = q_lift;
                  p_drag_in = q_drag_s;
                  p_mom_in  = q_mom_s;
                  if (gi_ff == '0) begin
                     res_d_in = q_drag_s;
                     res_m_in = q_mom_s;
                     low_in   = 1'b1;
                     state_in = S_NEXT;
                  end else begin
                     gi_in   = gi_ff - 1'b1;
                     rd_addr = AW'(gi_ff - 1'b1);
                  end
               end else if (first) begin
                  res_d_in  = q_drag_s;
                  res_m_in  = q_mom_s;
                  p_lift_in = q_lift;
                  stall_in  = 1'b1;
                  state_in  = S_CLIP;
               end else if (!same) begin
                  res_d_in = p_drag_ff;
                  res_m_in = p_mom_ff;
                  low_in   = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  ja_d_in  = q_drag_s;
                  ja_m_in  = q_mom_s;
                  jb_d_in  = p_drag_ff;
                  jb_m_in  = p_mom_ff;
                  jnum_in  = (RW+1)'(cl_ff) - (RW+1)'(q_lift);
                  jden_in  = (RW+1)'(p_lift_ff) - (RW+1)'(q_lift);
                  state_in = S_FRAC;
               end
            end else begin
               // walk up from the group bottom while lift is below the query
               cont = same && (q_lift < cl_ff);
               if (cont) begin
                  p_lift_in = q_lift;
                  p_drag_in = q_drag_s;
                  p_mom_in  = q_mom_s;
                  if (gi_ff + 1'b1 == count_ff) begin
                     res_d_in = q_drag_s;
                     res_m_in = q_mom_s;
                     stall_in = 1'b1;
                     state_in = S_CLIP;
                  end else begin
                     gi_in   = gi_ff + 1'b1;
                     rd_addr = AW'(gi_ff + 1'b1);
                  end
               end else if (!same) begin
                  res_d_in = p_drag_ff;
                  res_m_in = p_mom_ff;
                  stall_in = 1'b1;
                  state_in = S_CLIP;
               end else if (first) begin
                  res_d_in = q_drag_s;
                  res_m_in = q_mom_s;
                  low_in   = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  ja_d_in  = p_drag_ff;
                  ja_m_in  = p_mom_ff;
                  jb_d_in  = q_drag_s;
                  jb_m_in  = q_mom_s;
                  jnum_in  = (RW+1)'(cl_ff) - (RW+1)'(p_lift_ff);
                  jden_in  = (RW+1)'(q_lift) - (RW+1)'(p_lift_ff);
                  state_in = S_FRAC;
               end
            end
         end
         S_CLIP: begin
            // lift clipped to 0.825 of the group top
            mul_a    = 18'(p_lift_ff);
            mul_b    = signed'(pti_pkg::ClipQ16);
            prod_in  = mul_a * mul_b;
            state_in = S_CLIPW;
         end
         S_CLIPW: begin
            cl_in    = signed'(prod_ff[31:16]);
            state_in = S_NEXT;
         end
         S_FRAC: begin
            if (jden_ff <= 0 || jnum_ff <= 0) begin
               f_in     = '0;
               state_in = S_MULD;
            end else if (jnum_ff >= jden_ff) begin
               f_in     = pti_pkg::FracOne;
               state_in = S_MULD;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               f_in     = {1'b0, div_quo};
               state_in = S_MULD;
            end
         end
         S_MULD: begin
            mul_a    = 18'(jb_d_ff) - 18'(ja_d_ff);
            mul_b    = signed'({1'b0, f_ff});
            prod_in  = mul_a * mul_b;
            state_in = S_MULM;
         end
         S_MULM: begin
            res_d_in = ja_d_ff + signed'(prod_ff[32:16]);
            mul_a    = 18'(jb_m_ff) - 18'(ja_m_ff);
            mul_b    = signed'({1'b0, f_ff});
            prod_in  = mul_a * mul_b;
            state_in = S_MULF;
         end
         S_MULF: begin
            res_m_in = ja_m_ff + signed'(prod_ff[32:16]);
            state_in = S_NEXT;
         end
         S_NEXT: begin
            case (phase_ff)
               PH_LOWER: begin
                  // lower group done, search the upper one with the carried lift
                  cd1_in   = res_d_ff;
                  cm1_in   = res_m_ff;
                  phase_in = PH_UPPER;
                  up_in    = 1'b1;
                  top_in   = top_ff + 1'b1;
                  gi_in    = top_ff + 1'b1;
                  rd_addr  = AW'(top_ff + 1'b1);
                  state_in = S_GRP;
               end
               PH_UPPER: begin
                  ja_d_in  = cd1_ff;
                  ja_m_in  = cm1_ff;
                  jb_d_in  = res_d_ff;
                  jb_m_in  = res_m_ff;
                  jnum_in  = signed'({1'b0, re_ff}) - signed'({1'b0, rey_a_ff});
                  jden_in  = signed'({1'b0, rey_b_ff}) - signed'({1'b0, rey_a_ff});
                  phase_in = PH_REY;
                  state_in = S_FRAC;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.drag_out       = res_d_ff[KW-1:0];
               rsp_in.moment_out     = signed'(res_m_ff[KW-1:0]);
               rsp_in.lift_out       = cl_ff;
               rsp_in.stall_flag     = stall_ff;
               rsp_in.low_lift_flag  = low_ff;
               rsp_in.reynolds_range = range_ff;
               rsp_in.status         = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= {req_item.reynolds, req_item.lift_coef,
                                   req_item.drag_coef, req_item.moment_coef};
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_SINGLE;
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         f_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
         f_ff         <= f_in;
      end
      re_ff      <= re_in;
      lo_ff      <= lo_in;
      scan_ff    <= scan_in;
      prev_re_ff <= prev_re_in;
      rey_a_ff   <= rey_a_in;
      rey_b_ff   <= rey_b_in;
      top_ff     <= top_in;
      gi_ff      <= gi_in;
      gref_ff    <= gref_in;
      up_ff      <= up_in;
      cl_ff      <= cl_in;
      p_lift_ff  <= p_lift_in;
      p_drag_ff  <= p_drag_in;
      p_mom_ff   <= p_mom_in;
      res_d_ff   <= res_d_in;
      res_m_ff   <= res_m_in;
      cd1_ff     <= cd1_in;
      cm1_ff     <= cm1_in;
      ja_d_ff    <= ja_d_in;
      jb_d_ff    <= jb_d_in;
      ja_m_ff    <= ja_m_in;
      jb_m_ff    <= jb_m_in;
      jnum_ff    <= jnum_in;
      jden_ff    <= jden_in;
      prod_ff    <= prod_in;
      stall_ff   <= stall_in;
      low_ff     <= low_in;
      range_ff   <= range_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // row count never passes the table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pti_pkg::MaxRows))
      else $error("row count above table depth");

   // divider finishes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("divider result with no waiting sequencer");

   // a query on an empty table goes straight to the output stage
   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_item.cmd == pti_pkg::CmdQuery && count_ff == '0)
      |=> state_ff == S_OUT)
      else $error("empty table query did not finish at once");

   // interpolation fraction stays within one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      f_ff <= pti_pkg::FracOne)
      else $error("interpolation fraction above one");

endmodule
`default_nettype wire

### verif/testbench.sv
// self-checking testbench of the polar table interpolator
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pti_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pti_pkg::rsp_type rsp_item;

   polar_table_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // predictor copy of the polar table
   logic [pti_pkg::ReW-1:0]   tab_re   [pti_pkg::MaxRows];
   logic [pti_pkg::CoefW-1:0] tab_lift [pti_pkg::MaxRows];
   logic [pti_pkg::CoefW-1:0] tab_drag [pti_pkg::MaxRows];
   logic [pti_pkg::CoefW-1:0] tab_mom  [pti_pkg::MaxRows];
   int               tab_rows = 0;
   bit               tab_ended = 0;
   bit               q_stall, q_low;

   pti_pkg::rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      sent_count = 0, got_count = 0, query_count = 0, stall_count = 0;
   int      idle_cycles = 0;
   bit      hold_off = 0;
   bit      burst_mode = 1;

   function automatic longint sgn(logic [pti_pkg::CoefW-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint floor16(longint p);
      if (p >= 0) return p >>> 16;
      return -(((-p) + 65535) >>> 16);
   endfunction

   function automatic longint frac16(longint num, longint den);
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return 65536;
      return (num * 65536) / den;
   endfunction

   function automatic longint lerp16(longint a, longint b, longint f);
      return a + floor16((b - a) * f);
   endfunction

   function automatic longint clip16(longint top);
      return floor16(top * 54067);
   endfunction

   // walk down from the top row of a group
   task automatic walk_down(int top, inout longint cl, output longint cd, output longint cm);
      int i;
      logic [pti_pkg::ReW-1:0] re1;
      longint f;
      i = top;
      re1 = tab_re[top];
      while (i >= 0 && tab_re[i] == re1 && sgn(tab_lift[i]) > cl) i--;
      if (i == top) begin
         cd = tab_drag[top];
         cm = sgn(tab_mom[top]);
         cl = clip16(sgn(tab_lift[top]));
         q_stall = 1;
      end else if (i < 0 || tab_re[i] != re1) begin
         cd = tab_drag[i+1];
         cm = sgn(tab_mom[i+1]);
         q_low = 1;
      end else begin
         f = frac16(cl - sgn(tab_lift[i]), sgn(tab_lift[i+1]) - sgn(tab_lift[i]));
         cd = lerp16(tab_drag[i], tab_drag[i+1], f);
         cm = lerp16(sgn(tab_mom[i]), sgn(tab_mom[i+1]), f);
      end
   endtask

   // walk up from the bottom row of a group
   task automatic walk_up(int start, inout longint cl, output longint cd, output longint cm);
      int i;
      logic [pti_pkg::ReW-1:0] re2;
      longint f;
      i = start;
      re2 = tab_re[start];
      while (i < tab_rows && tab_re[i] == re2 && sgn(tab_lift[i]) < cl) i++;
      if (i == tab_rows || tab_re[i] != re2) begin
         cd = tab_drag[i-1];
         cm = sgn(tab_mom[i-1]);
         cl = clip16(sgn(tab_lift[i-1]));
         q_stall = 1;
      end else if (i == start) begin
         cd = tab_drag[i];
         cm = sgn(tab_mom[i]);
         q_low = 1;
      end else begin
         f = frac16(cl - sgn(tab_lift[i-1]), sgn(tab_lift[i]) - sgn(tab_lift[i-1]));
         cd = lerp16(tab_drag[i-1], tab_drag[i], f);
         cm = lerp16(sgn(tab_mom[i-1]), sgn(tab_mom[i]), f);
      end
   endtask

   // predict the result of one item and update the table copy
   task automatic predict_polar(pti_pkg::req_type it);
      pti_pkg::rsp_type r;
      longint  cl, cd, cm, cd1, cm1, cd2, cm2, f;
      int      i, idx;
      r = '0;
      cl = sgn(it.lift_coef);
      cd = 0;
      cm = 0;
      q_stall = 0;
      q_low = 0;
      case (it.cmd)
         pti_pkg::CmdClear: begin
            tab_rows = 0;
            tab_ended = 0;
         end
         pti_pkg::CmdAppend: begin
            if (tab_ended) r.status = pti_pkg::StatEnded;
            else if (it.reynolds == 0) tab_ended = 1;
            else if (tab_rows >= pti_pkg::MaxRows) r.status = pti_pkg::StatFull;
            else begin
               tab_re[tab_rows] = it.reynolds;
               tab_lift[tab_rows] = it.lift_coef;
               tab_drag[tab_rows] = it.drag_coef;
               tab_mom[tab_rows] = it.moment_coef;
               tab_rows++;
            end
         end
         pti_pkg::CmdQuery: begin
            if (tab_rows == 0) begin
               r.status = pti_pkg::StatEmpty;
               r.lift_out = it.lift_coef;
            end else begin
               if (it.reynolds > tab_re[0] && it.reynolds < tab_re[tab_rows-1]) begin
                  i = 0;
                  while (i < tab_rows - 1 && tab_re[i] < it.reynolds) i++;
                  idx = (i > 0) ? i - 1 : 0;
                  if (idx > tab_rows - 2) idx = tab_rows - 2;
                  walk_down(idx, cl, cd1, cm1);
                  walk_up(idx + 1, cl, cd2, cm2);
                  f = frac16(longint'(it.reynolds) - tab_re[idx],
                             longint'(tab_re[idx+1]) - tab_re[idx]);
                  cd = lerp16(cd1, cd2, f);
                  cm = lerp16(cm1, cm2, f);
                  r.reynolds_range = pti_pkg::RangeIn;
               end else if (it.reynolds >= tab_re[tab_rows-1]) begin
                  r.reynolds_range = pti_pkg::RangeAbove;
                  walk_down(tab_rows - 1, cl, cd, cm);
               end else begin
                  r.reynolds_range = pti_pkg::RangeBelow;
                  walk_up(0, cl, cd, cm);
               end
               r.lift_out = cl[15:0];
               r.drag_out = cd[15:0];
               r.moment_out = cm[15:0];
               r.stall_flag = q_stall;
               r.low_lift_flag = q_low;
            end
            query_count++;
            if (q_stall) stall_count++;
         end
         default: ;
      endcase
      expected_rsps.push_back(r);
   endtask

   // send one item, with burst and gap idling on the request side
   task automatic send_item(pti_pkg::req_type it);
      int gap;
      if (!burst_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      predict_polar(it);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      req_valid <= 1'b0;
      // block is busy for at least the next cycle after taking an item
      @(posedge clock);
      if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic pti_pkg::req_type make_item(logic [1:0] c, logic [pti_pkg::ReW-1:0] re,
                                         logic [15:0] cl, logic [15:0] cd, logic [15:0] cm);
      pti_pkg::req_type it;
      it.cmd = c;
      it.reynolds = re;
      it.lift_coef = cl;
      it.drag_coef = cd;
      it.moment_coef = cm;
      return it;
   endfunction

   // append a sorted table of ngroups groups with nper rows each
   task automatic load_sorted_table(int ngroups, int nper, int re_span);
      logic [pti_pkg::ReW-1:0] re;
      int cl;
      send_item(make_item(pti_pkg::CmdClear, 0, 0, 0, 0));
      re = $urandom_range(1, 1000);
      for (int g = 0; g < ngroups; g++) begin
         cl = $urandom_range(0, 8000) - 12000;
         for (int k = 0; k < nper; k++) begin
            send_item(make_item(pti_pkg::CmdAppend, re, cl[15:0], 16'($urandom),
                                16'($urandom)));
            cl = cl + $urandom_range(1, 24000 / nper);
         end
         re = re + $urandom_range(1, re_span);
      end
   endtask

   task automatic random_query();
      logic [pti_pkg::ReW-1:0] re;
      int sel;
      sel = $urandom_range(0, 9);
      if (tab_rows > 0 && sel < 8)
         re = tab_re[0] + $urandom_range(0, tab_re[tab_rows-1] - tab_re[0] + 2)
              - (sel == 0 ? 1 : 0);
      else
         re = $urandom;
      send_item(make_item(pti_pkg::CmdQuery, re, 16'($urandom), 16'($urandom),
                          16'($urandom)));
   endtask

   // directed: empty table, extremes, end marker, unused code
   task automatic test_directed();
      send_item(make_item(pti_pkg::CmdQuery, 24'd500, 16'h8000, 0, 0));
      send_item(make_item(pti_pkg::CmdAppend, 24'hFFFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF));
      send_item(make_item(pti_pkg::CmdQuery, 24'hFFFFFF, 16'h7FFF, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd0, 16'h8000, 0, 0));
      send_item(make_item(pti_pkg::CmdClear, 0, 0, 0, 0));
      send_item(make_item(pti_pkg::CmdAppend, 24'd100, 16'hF000, 16'd100, 16'h8000));
      send_item(make_item(pti_pkg::CmdAppend, 24'd100, 16'h1000, 16'd900, 16'h0100));
      send_item(make_item(pti_pkg::CmdAppend, 24'd300, 16'hE000, 16'd200, 16'h0200));
      send_item(make_item(pti_pkg::CmdAppend, 24'd300, 16'h2000, 16'hFFFF, 16'h7FFF));
      send_item(make_item(pti_pkg::CmdQuery, 24'd200, 16'h0000, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd200, 16'h1000, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd200, 16'h8000, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd300, 16'h2000, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd100, 16'h1800, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd50, 16'hF000, 0, 0));
      send_item(make_item(pti_pkg::CmdAppend, 24'd0, 0, 0, 0));
      send_item(make_item(pti_pkg::CmdAppend, 24'd400, 0, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd301, 16'h0000, 0, 0));
      send_item(make_item(pti_pkg::CmdUnused, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      wait_drained();
   endtask

   // fill the table to the limit, then two more appends get dropped
   task automatic test_full_table();
      send_item(make_item(pti_pkg::CmdClear, 0, 0, 0, 0));
      for (int k = 0; k < pti_pkg::MaxRows + 2; k++)
         send_item(make_item(pti_pkg::CmdAppend, 24'(k / 4 + 1),
                             16'((k % 4) * 2000 - 3000), 16'($urandom), 16'($urandom)));
      send_item(make_item(pti_pkg::CmdQuery, 24'd30, 16'h0800, 0, 0));
      send_item(make_item(pti_pkg::CmdQuery, 24'd64, 16'h7FFF, 0, 0));
      wait_drained();
   endtask

   // well-formed tables with random queries, a little noise mixed in
   task automatic test_random();
      int n;
      n = 0;
      while (n < 220) begin
         load_sorted_table($urandom_range(1, 4), $urandom_range(1, 4),
                           $urandom_range(1, 3) == 1 ? 1 : 2000);
         n += 10;
         repeat ($urandom_range(8, 20)) begin
            if ($urandom_range(0, 14) == 0)
               send_item(make_item(2'($urandom), 24'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom)));
            else
               random_query();
            n++;
         end
      end
      wait_drained();
   endtask

   // receiver holds off long so the block stalls its input
   task automatic test_backpressure();
      hold_off = 1;
      load_sorted_table(2, 2, 100);
      repeat (6) random_query();
      hold_off = 0;
      wait_drained();
   endtask

   // receiver stall pattern plus the long hold-off
   int stall_phase = 0;
   int hold_count = 0;
   always @(posedge clock) begin
      if (hold_off && hold_count < 300) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_off) hold_count <= 0;
         stall_phase <= (stall_phase + 1) % 23;
         rsp_ready <= (stall_phase < 7) ? 1'b1 : (stall_phase < 12) ? 1'b0
                      : ($urandom_range(0, 2) != 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      pti_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         got_count++;
         if (expected_rsps.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.drag_out !== e.drag_out) begin
               $error("drag_out expected %h actual %h", e.drag_out, rsp_item.drag_out);
               fail_count++;
            end
            if (rsp_item.moment_out !== e.moment_out) begin
               $error("moment_out expected %h actual %h", e.moment_out, rsp_item.moment_out);
               fail_count++;
            end
            if (rsp_item.lift_out !== e.lift_out) begin
               $error("lift_out expected %h actual %h", e.lift_out, rsp_item.lift_out);
               fail_count++;
            end
            if (rsp_item.stall_flag !== e.stall_flag) begin
               $error("stall_flag expected %b actual %b", e.stall_flag, rsp_item.stall_flag);
               fail_count++;
            end
            if (rsp_item.low_lift_flag !== e.low_lift_flag) begin
               $error("low_lift_flag expected %b actual %b", e.low_lift_flag,
                      rsp_item.low_lift_flag);
               fail_count++;
            end
            if (rsp_item.reynolds_range !== e.reynolds_range) begin
               $error("reynolds_range expected %d actual %d", e.reynolds_range,
                      rsp_item.reynolds_range);
               fail_count++;
            end
            if (rsp_item.status !== e.status) begin
               $error("status expected %d actual %d", e.status, rsp_item.status);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      if (expected_rsps.size() != 0) fail_count++;
      $display("sent %0d items, checked %0d results, %0d queries with %0d stalls",
               sent_count, got_count, query_count, stall_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
